### sv/fcsg_pkg.sv
`timescale 1ns / 1ps
package fcsg_pkg;

  localparam int MAX_RADIUS = 30;
  localparam int COORD_BITS = 12;
  localparam int RADIUS_W   = 8;
  localparam int ANCHOR_W   = 4;
  localparam int COLOR_W    = 16;

  // Span coordinates carry one bit more than the center.
  localparam int SPAN_W     = COORD_BITS + 1;
  // Radius counters must hold MAX_RADIUS + 1 (px runs one past py).
  localparam int RAD_W      = $clog2(MAX_RADIUS + 2);
  // Midpoint decision value, signed.
  localparam int D_W        = RAD_W + 4;
  localparam int SPAN_LIMIT = 2 * MAX_RADIUS + 1;
  localparam int CNT_W      = $clog2(SPAN_LIMIT + 1);

  // Anchor bits.
  localparam int ANCHOR_LEFT   = 0;
  localparam int ANCHOR_RIGHT  = 1;
  localparam int ANCHOR_TOP    = 2;
  localparam int ANCHOR_BOTTOM = 3;

  typedef struct packed {
    logic signed [SPAN_W-1:0] cx;
    logic signed [SPAN_W-1:0] cy;
    logic [RAD_W-1:0]         r;
    logic [COLOR_W-1:0]       color;
  } cmd_t;

  typedef struct packed {
    logic signed [SPAN_W-1:0] row;
    logic signed [SPAN_W-1:0] left;
    logic signed [SPAN_W-1:0] right;
    logic [COLOR_W-1:0]       color;
    logic                     last;
  } span_t;

endpackage

### sv/fcsg_front.sv
`timescale 1ns / 1ps
module fcsg_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [fcsg_pkg::COORD_BITS-1:0]  in_center_x,
  input  logic signed [fcsg_pkg::COORD_BITS-1:0]  in_center_y,
  input  logic [fcsg_pkg::RADIUS_W-1:0]           in_radius,
  input  logic [fcsg_pkg::ANCHOR_W-1:0]           in_anchor_mode,
  input  logic [fcsg_pkg::COLOR_W-1:0]            in_color,
  output logic                                    cmd_valid,
  input  logic                                    cmd_pop,
  output fcsg_pkg::cmd_t                          cmd
);
  import fcsg_pkg::*;

  logic [RAD_W-1:0]         r_cl;
  logic [RAD_W-1:0]         half;
  logic signed [SPAN_W-1:0] h_s;
  logic signed [SPAN_W-1:0] cx_sh;
  logic signed [SPAN_W-1:0] cy_sh;
  cmd_t                     cmd_new;

  cmd_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;

  // Clamp, then shift the center by ceil(r/2) per anchor bit.
  always_comb begin
    r_cl  = (in_radius > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                : in_radius[RAD_W-1:0];
    half  = (r_cl >> 1) + RAD_W'(r_cl[0]);
    h_s   = SPAN_W'(half);
    cx_sh = SPAN_W'(in_center_x);
    cy_sh = SPAN_W'(in_center_y);
    if (in_anchor_mode[ANCHOR_LEFT])   cx_sh = cx_sh + h_s;
    if (in_anchor_mode[ANCHOR_RIGHT])  cx_sh = cx_sh - h_s;
    if (in_anchor_mode[ANCHOR_TOP])    cy_sh = cy_sh + h_s;
    if (in_anchor_mode[ANCHOR_BOTTOM]) cy_sh = cy_sh - h_s;
    cmd_new.cx    = cx_sh;
    cmd_new.cy    = cy_sh;
    cmd_new.r     = r_cl;
    cmd_new.color = in_color;
  end

  // Two-entry command queue.
  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = mem_r[rd_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    wr_nxt  = push_ok ? ~wr_r : wr_r;
    rd_nxt  = pop_ok ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= cmd_new;
    end
  end

endmodule

### sv/fcsg_back.sv
`timescale 1ns / 1ps
module fcsg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  fcsg_pkg::cmd_t  cmd,
  output logic            span_push,
  input  logic            span_full,
  output fcsg_pkg::span_t span_out
);
  import fcsg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_A     = 3'd3;
  localparam logic [2:0] S_B     = 3'd4;
  localparam logic [2:0] S_C     = 3'd5;
  localparam logic [2:0] S_D     = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]               st_r, st_nxt;
  logic [RAD_W-1:0]         px_r, px_nxt;
  logic [RAD_W-1:0]         py_r, py_nxt;
  logic signed [D_W-1:0]    d_r, d_nxt;
  logic signed [SPAN_W-1:0] cx_r, cx_nxt;
  logic signed [SPAN_W-1:0] cy_r, cy_nxt;
  logic [COLOR_W-1:0]       col_r, col_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  span_t                    pend_r, pend_nxt;
  logic                     pend_v_r, pend_v_nxt;

  logic                     emit;
  logic                     fin;
  logic                     stall;
  logic                     keep;
  logic signed [SPAN_W-1:0] px_s;
  logic signed [SPAN_W-1:0] py_s;
  logic signed [D_W-1:0]    px_d;
  logic signed [D_W-1:0]    py_d;
  span_t                    span_new;

  assign px_s = SPAN_W'(px_r);
  assign py_s = SPAN_W'(py_r);
  assign px_d = D_W'(px_r);
  assign py_d = D_W'(py_r);

  assign emit  = (st_r == S_FIRST) || (st_r == S_A) || (st_r == S_B) ||
                 (st_r == S_D) || ((st_r == S_C) && (py_r >= px_r));
  assign fin   = (st_r == S_DONE);
  assign stall = (emit || fin) && pend_v_r && span_full;
  assign keep  = (cnt_r < CNT_W'(SPAN_LIMIT));

  // Span for the current step.
  always_comb begin
    span_new.color = col_r;
    span_new.last  = 1'b0;
    span_new.row   = cy_r;
    span_new.left  = cx_r - py_s;
    span_new.right = cx_r + py_s;
    case (st_r)
      S_A: begin
        span_new.row   = cy_r + py_s + SPAN_W'(1);
        span_new.left  = cx_r - px_s;
        span_new.right = cx_r + px_s;
      end
      S_B: begin
        span_new.row   = cy_r - py_s - SPAN_W'(1);
        span_new.left  = cx_r - px_s;
        span_new.right = cx_r + px_s;
      end
      S_C: begin
        span_new.row = cy_r + px_s;
      end
      S_D: begin
        span_new.row = cy_r - px_s;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    d_nxt      = d_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cmd_pop    = 1'b0;
    span_push  = 1'b0;
    span_out   = pend_r;
    span_out.last = fin;

    if (!stall) begin
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_pop = 1'b1;
            cx_nxt  = cmd.cx;
            cy_nxt  = cmd.cy;
            col_nxt = cmd.color;
            px_nxt  = '0;
            py_nxt  = cmd.r;
            d_nxt   = D_W'(1) - D_W'(cmd.r);
            cnt_nxt = '0;
            st_nxt  = S_FIRST;
          end
        end
        S_FIRST: st_nxt = S_TEST;
        S_TEST: begin
          if (py_r > px_r) begin
            if (d_r[D_W-1]) begin
              d_nxt  = D_W'(d_r + 2 * px_d + 3);
              px_nxt = px_r + RAD_W'(1);
              st_nxt = S_C;
            end else begin
              d_nxt  = D_W'(d_r + 2 * (px_d - py_d) + 5);
              py_nxt = py_r - RAD_W'(1);
              st_nxt = S_A;
            end
          end else begin
            st_nxt = S_DONE;
          end
        end
        S_A: st_nxt = S_B;
        S_B: begin
          px_nxt = px_r + RAD_W'(1);
          st_nxt = S_C;
        end
        S_C: st_nxt = (py_r >= px_r) ? S_D : S_TEST;
        S_D: st_nxt = S_TEST;
        S_DONE: begin
          span_push  = pend_v_r;
          pend_v_nxt = 1'b0;
          st_nxt     = S_IDLE;
        end
        default: st_nxt = S_IDLE;
      endcase

      // Hold one span back so the final one can be marked.
      if (emit && keep) begin
        span_push  = pend_v_r;
        pend_nxt   = span_new;
        pend_v_nxt = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    d_r    <= d_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    col_r  <= col_nxt;
    pend_r <= pend_nxt;
  end

endmodule

### sv/fcsg_out_q.sv
`timescale 1ns / 1ps
module fcsg_out_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            span_push,
  output logic            span_full,
  input  fcsg_pkg::span_t span_in,
  output logic            out_empty,
  input  logic            out_pop,
  output fcsg_pkg::span_t span_head
);
  import fcsg_pkg::*;

  span_t      mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;

  assign span_full = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign span_head = mem_r[rd_r];
  assign push_ok   = span_push && !span_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    wr_nxt  = push_ok ? ~wr_r : wr_r;
    rd_nxt  = pop_ok ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= span_in;
    end
  end

endmodule

### sv/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// Channel   | Ports                                        | Beat moves when
// ----------+----------------------------------------------+------------------------
// request   | in_push/in_full, in_center_x/y, in_radius,   | in_push && !in_full
//           | in_anchor_mode, in_color                     |
// span      | out_empty/out_pop, out_span_row/left/right,  | out_pop && !out_empty
//           | out_span_color, out_last_span                |
//
// A circle of clamped radius r gives n spans (n <= 2r + 1). The span sequencer
// emits at most one span per cycle and works on one circle at a time.
// Reset (rst_n low at a clock edge) empties both queues and idles the sequencer.
// A full span queue stalls the sequencer; the two-entry request queue keeps
// taking requests meanwhile.
module filled_circle_span_generator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [fcsg_pkg::COORD_BITS-1:0]  in_center_x,
  input  logic signed [fcsg_pkg::COORD_BITS-1:0]  in_center_y,
  input  logic [fcsg_pkg::RADIUS_W-1:0]           in_radius,
  input  logic [fcsg_pkg::ANCHOR_W-1:0]           in_anchor_mode,
  input  logic [fcsg_pkg::COLOR_W-1:0]            in_color,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_row,
  output logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_left,
  output logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_right,
  output logic [fcsg_pkg::COLOR_W-1:0]            out_span_color,
  output logic                                    out_last_span
);
  import fcsg_pkg::*;

  logic  cmd_valid;
  logic  cmd_pop;
  cmd_t  cmd;
  logic  span_push;
  logic  span_full;
  span_t span_in;
  span_t span_head;

  // Front: clamp radius, apply anchor shifts, queue the command.
  fcsg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_anchor_mode (in_anchor_mode),
    .in_color       (in_color),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd)
  );

  // Back: midpoint recurrence, two or four spans per step, holds one span to mark last.
  fcsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .span_push (span_push),
    .span_full (span_full),
    .span_out  (span_in)
  );

  // Output queue decouples the sequencer from the consumer.
  fcsg_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .span_push (span_push),
    .span_full (span_full),
    .span_in   (span_in),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .span_head (span_head)
  );

  assign out_span_row   = span_head.row;
  assign out_span_left  = span_head.left;
  assign out_span_right = span_head.right;
  assign out_span_color = span_head.color;
  assign out_last_span  = span_head.last;

endmodule

### sv/fcsg_checker.sv
`timescale 1ns / 1ps
module fcsg_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    out_empty,
  input  logic                                    out_pop,
  input  logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_row,
  input  logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_left,
  input  logic signed [fcsg_pkg::SPAN_W-1:0]      out_span_right,
  input  logic [fcsg_pkg::COLOR_W-1:0]            out_span_color,
  input  logic                                    out_last_span
);
  import fcsg_pkg::*;

  logic signed [SPAN_W:0] width;
  assign width = (SPAN_W + 1)'(out_span_right) - (SPAN_W + 1)'(out_span_left);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("span queue not empty after reset");

  a_left_le_right: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> width >= 0)
    else $error("span left beyond right");

  a_width_odd: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> width[0] == 1'b0)
    else $error("span pixel count not odd");

  a_width_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> width <= (SPAN_W + 1)'(2 * MAX_RADIUS))
    else $error("span wider than clamped diameter");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_span_row) &&
      $stable(out_span_left) && $stable(out_span_right) &&
      $stable(out_span_color) && $stable(out_last_span)))
    else $error("waiting span changed before pop");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);
